// ===== src/fng_pkg.sv =====
// Package for the face normal generator: command and status types,
// primitive codes and small phase arithmetic helpers. No dependencies.
`timescale 1ns / 1ps
package fng_pkg;

  // Primitive type codes held in the configuration register.
  localparam logic [1:0] PRIM_LIST  = 2'd0;
  localparam logic [1:0] PRIM_STRIP = 2'd1;
  localparam logic [1:0] PRIM_QUAD  = 2'd2;
  localparam logic [1:0] PRIM_POLY  = 2'd3;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned NORM_W  = 16;
  localparam int unsigned CROSS_W = 62;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       load_poly;
    logic       scale;
    logic       mul;
    logic       zero;
    logic       norm;
    logic       sq;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_wr;
    logic       fin;
    logic       store_poly;
    logic [2:0] cnt;
    logic [1:0] comp;
  } fng_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_zero;
    logic norm_done;
  } fng_sts_t;

  // Group stride of the list, strip and quad modes.
  function automatic logic [2:0] stride_of(input logic [1:0] prim);
    logic [2:0] s;
    case (prim)
      PRIM_LIST:  s = 3'd3;
      PRIM_STRIP: s = 3'd2;
      PRIM_QUAD:  s = 3'd4;
      default:    s = 3'd3;
    endcase
    return s;
  endfunction

  // Remainder of a small phase value by a stride of 2, 3 or 4.
  function automatic logic [2:0] mod_stride(input logic [2:0] v, input logic [2:0] s);
    logic [2:0] r;
    case (s)
      3'd2: r = {2'b00, v[0]};
      3'd4: r = {1'b0, v[1:0]};
      default: begin
        case (v)
          3'd0, 3'd3, 3'd6: r = 3'd0;
          3'd1, 3'd4, 3'd7: r = 3'd1;
          default:          r = 3'd2;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

// ===== src/fng_ctrl.sv =====
// Controller of the face normal generator: configuration register, primitive
// phase, and the sequencer that steps the datapath. Depends on fng_pkg.
`timescale 1ns / 1ps
module fng_ctrl import fng_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_last,
  output fng_cmd_t   cmd,
  input  fng_sts_t   sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCALE = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_NORM  = 4'd4;
  localparam logic [3:0] S_SQ    = 4'd5;
  localparam logic [3:0] S_SQI   = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_DIVI  = 4'd8;
  localparam logic [3:0] S_DIVS  = 4'd9;
  localparam logic [3:0] S_DIVW  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [1:0] prim_r;
  logic [2:0] phase_r, phase_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [2:0] total_r, total_nxt;
  logic [2:0] emit_r, emit_nxt;
  logic       spoly_r, spoly_nxt;

  logic [2:0] stride;
  logic [2:0] step_up;
  logic       grp_hit;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid & in_ready;
  assign stride    = stride_of(prim_r);
  assign step_up   = phase_r + 3'd1;
  assign grp_hit   = (phase_r >= 3'd2) && (mod_stride(phase_r - 3'd2, stride) == 3'd0);

  // Phase after this vertex; the end flag restarts the primitive.
  always_comb begin
    if (in_last) begin
      phase_nxt = 3'd0;
    end else if (prim_r == PRIM_POLY) begin
      phase_nxt = (phase_r >= 3'd3) ? 3'd3 : step_up;
    end else if (step_up >= 3'd2) begin
      phase_nxt = 3'd2 + mod_stride(step_up - 3'd2, stride);
    end else begin
      phase_nxt = step_up;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    comp_nxt  = comp_r;
    total_nxt = total_r;
    emit_nxt  = emit_r;
    spoly_nxt = spoly_r;
    cmd       = '0;
    cmd.cnt   = cnt_r[2:0];
    cmd.comp  = comp_r;
    cmd.store_poly = spoly_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.accept = 1'b1;
          emit_nxt   = 3'd0;
          if (prim_r == PRIM_POLY) begin
            if (phase_r == 3'd2) begin
              total_nxt = 3'd3;
              spoly_nxt = 1'b1;
              state_nxt = S_SCALE;
            end else if (phase_r >= 3'd3) begin
              cmd.load_poly = 1'b1;
              total_nxt = 3'd1;
              state_nxt = S_EMIT;
            end
          end else if (grp_hit) begin
            total_nxt = stride;
            spoly_nxt = 1'b0;
            state_nxt = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (cnt_r == 5'd6) begin
          state_nxt = S_CHK;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_CHK: begin
        if (sts.is_zero) begin
          cmd.zero  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (sts.norm_done) begin
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end else begin
          cmd.norm = 1'b1;
        end
      end
      S_SQ: begin
        cmd.sq = 1'b1;
        if (cnt_r == 5'd3) begin
          state_nxt = S_SQI;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          comp_nxt  = 2'd0;
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd14) begin
          state_nxt = S_DIVW;
        end
      end
      S_DIVW: begin
        cmd.div_wr = 1'b1;
        if (comp_r == 2'd2) begin
          state_nxt = S_FIN;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_DIVI;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        out_last  = (emit_r == total_r - 3'd1);
        if (out_ready) begin
          if (out_last) begin
            state_nxt = S_IDLE;
          end else begin
            emit_nxt = emit_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      prim_r  <= PRIM_LIST;
      phase_r <= '0;
      cnt_r   <= '0;
      comp_r  <= '0;
      total_r <= '0;
      emit_r  <= '0;
      spoly_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      comp_r  <= comp_nxt;
      total_r <= total_nxt;
      emit_r  <= emit_nxt;
      spoly_r <= spoly_nxt;
      if (cfg_valid && cfg_ready) begin
        prim_r <= cfg_data;
      end
      if (accept) begin
        phase_r <= phase_nxt;
      end
    end
  end

endmodule

// ===== src/fng_dp.sv =====
// Datapath of the face normal generator: held vertices, edge scaling, shared
// multiplier, normalizing shifter, square root and divider. Depends on fng_pkg.
`timescale 1ns / 1ps
module fng_dp import fng_pkg::*; #(
  parameter int unsigned NORM_FRAC_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] pos_z,
  input  fng_cmd_t                  cmd,
  output fng_sts_t                  sts,
  output logic signed [NORM_W-1:0]  norm_x,
  output logic signed [NORM_W-1:0]  norm_y,
  output logic signed [NORM_W-1:0]  norm_z
);

  localparam int unsigned NUM_W = 31 + NORM_FRAC_BITS;
  localparam int unsigned DW    = (NUM_W > 47) ? NUM_W : 47;

  logic signed [COORD_W-1:0] hva_r [3];
  logic signed [COORD_W-1:0] hvb_r [3];
  logic signed [COORD_W:0]   d_r [3];
  logic signed [COORD_W:0]   e_r [3];
  logic signed [31:0]        sd_r [3];
  logic signed [31:0]        se_r [3];
  logic signed [63:0]        p_r;
  logic signed [63:0]        t_r;
  logic                      cs_r [3];
  logic [CROSS_W-1:0]        cm_r [3];
  logic [63:0]               s_r;
  logic [63:0]               rn_r, rt_r, rb_r;
  logic [DW-1:0]             rem_r, dv_r;
  logic [14:0]               q_r;
  logic                      ovf_r;
  logic signed [NORM_W-1:0]  res_r [3];
  logic signed [NORM_W-1:0]  poly_r [3];

  logic signed [COORD_W-1:0] vin [3];
  logic [1:0]                kshift;
  logic signed [31:0]        sd_nxt [3];
  logic signed [31:0]        se_nxt [3];
  logic signed [31:0]        ma, mb;
  logic signed [63:0]        diff;
  logic [63:0]               diff_mag;
  logic [2:0]                j;
  logic [1:0]                sq_sel;
  logic [63:0]               rsum;
  logic [30:0]               len;
  logic [DW-1:0]             num;
  logic [DW-1:0]             lim;
  logic [14:0]               qq;
  logic [NORM_W-1:0]         qv;
  logic                      any_hi, any_29;

  assign vin[0] = pos_x;
  assign vin[1] = pos_y;
  assign vin[2] = pos_z;

  // Scale the edge vectors so that every component fits in 31 bits.
  always_comb begin
    logic [COORD_W:0] dm, em;
    logic over30, over31;
    over30 = 1'b0;
    over31 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dm = d_r[i][COORD_W] ? -d_r[i] : d_r[i];
      em = e_r[i][COORD_W] ? -e_r[i] : e_r[i];
      over30 = over30 | (dm > 33'h040000000) | (em > 33'h040000000);
      over31 = over31 | ((dm >> 1) > 33'h040000000) | ((em >> 1) > 33'h040000000);
    end
    kshift = over31 ? 2'd2 : (over30 ? 2'd1 : 2'd0);
    for (int i = 0; i < 3; i++) begin
      dm = d_r[i][COORD_W] ? -d_r[i] : d_r[i];
      em = e_r[i][COORD_W] ? -e_r[i] : e_r[i];
      dm = dm >> kshift;
      em = em >> kshift;
      sd_nxt[i] = d_r[i][COORD_W] ? -$signed(dm[31:0]) : $signed(dm[31:0]);
      se_nxt[i] = e_r[i][COORD_W] ? -$signed(em[31:0]) : $signed(em[31:0]);
    end
  end

  // Operand select for the shared multiplier.
  assign sq_sel = (cmd.cnt < 3'd3) ? cmd.cnt[1:0] : 2'd0;
  always_comb begin
    ma = sd_r[0];
    mb = se_r[0];
    if (cmd.sq) begin
      ma = $signed({2'b00, cm_r[sq_sel][29:0]});
      mb = ma;
    end else begin
      case (cmd.cnt)
        3'd0: begin ma = sd_r[1]; mb = se_r[2]; end
        3'd1: begin ma = sd_r[2]; mb = se_r[1]; end
        3'd2: begin ma = sd_r[2]; mb = se_r[0]; end
        3'd3: begin ma = sd_r[0]; mb = se_r[2]; end
        3'd4: begin ma = sd_r[0]; mb = se_r[1]; end
        3'd5: begin ma = sd_r[1]; mb = se_r[0]; end
        default: begin ma = sd_r[0]; mb = se_r[0]; end
      endcase
    end
  end

  assign j        = cmd.cnt - 3'd1;
  assign diff     = t_r - p_r;
  assign diff_mag = diff[63] ? -diff : diff;

  // Normalizer status.
  always_comb begin
    any_hi = 1'b0;
    any_29 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      any_hi = any_hi | (|cm_r[i][CROSS_W-1:30]);
      any_29 = any_29 | cm_r[i][29];
    end
  end
  assign sts.norm_done = !any_hi && any_29;
  assign sts.is_zero   = (cm_r[0] == '0) && (cm_r[1] == '0) && (cm_r[2] == '0);

  // Square root step and divider operands.
  assign rsum = rt_r + rb_r;
  assign len  = rt_r[30:0];
  assign num  = ({{(DW-30){1'b0}}, cm_r[cmd.comp][29:0]} << NORM_FRAC_BITS)
              + {{(DW-30){1'b0}}, len[30:1]};
  assign lim  = {{(DW-46){1'b0}}, len, 15'd0};
  assign qq   = ovf_r ? 15'h7fff : q_r;
  assign qv   = {1'b0, qq};

  // Held vertices and the stored polygon normal.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        hva_r[i]  <= '0;
        hvb_r[i]  <= '0;
        poly_r[i] <= '0;
      end
    end else begin
      if (cmd.accept) begin
        for (int i = 0; i < 3; i++) begin
          hva_r[i] <= hvb_r[i];
          hvb_r[i] <= vin[i];
        end
      end
      if (cmd.fin && cmd.store_poly) begin
        for (int i = 0; i < 3; i++) begin
          poly_r[i] <= res_r[i];
        end
      end
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= {hva_r[i][COORD_W-1], hva_r[i]} - {hvb_r[i][COORD_W-1], hvb_r[i]};
        e_r[i] <= {hvb_r[i][COORD_W-1], hvb_r[i]} - {vin[i][COORD_W-1], vin[i]};
      end
    end
    if (cmd.scale) begin
      for (int i = 0; i < 3; i++) begin
        sd_r[i] <= sd_nxt[i];
        se_r[i] <= se_nxt[i];
      end
      s_r <= '0;
    end
    if (cmd.mul || cmd.sq) begin
      p_r <= ma * mb;
    end
    // Cross product: even products are held, odd ones are subtracted.
    if (cmd.mul && cmd.cnt != 3'd0) begin
      if (!j[0]) begin
        t_r <= p_r;
      end else begin
        cs_r[j[2:1]] <= diff[63];
        cm_r[j[2:1]] <= diff_mag[CROSS_W-1:0];
      end
    end
    // One bit of normalizing shift per cycle.
    if (cmd.norm) begin
      for (int i = 0; i < 3; i++) begin
        cm_r[i] <= any_hi ? (cm_r[i] >> 1) : (cm_r[i] << 1);
      end
    end
    if (cmd.sq && cmd.cnt != 3'd0) begin
      s_r <= s_r + p_r;
    end
    if (cmd.sqrt_init) begin
      rn_r <= s_r;
      rt_r <= '0;
      rb_r <= 64'h4000000000000000;
    end
    if (cmd.sqrt_step) begin
      if (rn_r >= rsum) begin
        rn_r <= rn_r - rsum;
        rt_r <= (rt_r >> 1) + rb_r;
      end else begin
        rt_r <= rt_r >> 1;
      end
      rb_r <= rb_r >> 2;
    end
    if (cmd.div_init) begin
      rem_r <= num;
      dv_r  <= {{(DW-45){1'b0}}, len, 14'd0};
      q_r   <= '0;
      ovf_r <= (num >= lim);
    end
    if (cmd.div_step) begin
      if (rem_r >= dv_r) begin
        rem_r <= rem_r - dv_r;
        q_r   <= {q_r[13:0], 1'b1};
      end else begin
        q_r   <= {q_r[13:0], 1'b0};
      end
      dv_r <= dv_r >> 1;
    end
    if (cmd.div_wr) begin
      res_r[cmd.comp] <= cs_r[cmd.comp] ? -$signed(qv) : $signed(qv);
    end
    if (cmd.zero) begin
      for (int i = 0; i < 3; i++) begin
        res_r[i] <= '0;
      end
    end
    if (cmd.load_poly) begin
      for (int i = 0; i < 3; i++) begin
        res_r[i] <= poly_r[i];
      end
    end
  end

  assign norm_x = res_r[0];
  assign norm_y = res_r[1];
  assign norm_z = res_r[2];

endmodule

// ===== src/face_normal_generator_top.sv =====
// Top level of the face normal generator: joins the controller and the
// datapath to the stream ports. Depends on fng_pkg, fng_ctrl and fng_dp.
//
//  Port group  Direction  Moves
//  in_*        slave      one vertex per transfer, tlast on the primitive's last vertex
//  out_*       master     one normal per transfer, tlast on a vertex's last normal
//  cfg_*       slave      primitive type, taken in any cycle
//
// A vertex starting no group is just taken; a polygon repeat shows the stored normal.
// A completed group shows its first normal after edge scaling, the cross product (a zero
// cross product goes straight to the output), one-bit normalizing shifts, a 32-step square
// root and three divisions; then one copy per cycle while the output is ready.
// Reset clears the primitive type, phase, held vertices and polygon normal.
// A stalled output holds its normal; no vertex is taken until all copies leave.
`timescale 1ns / 1ps
module face_normal_generator_top import fng_pkg::*; #(
  parameter int unsigned NORM_FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // pos_x, pos_y, pos_z
  input  logic        in_tlast,   // prim_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // norm_x, norm_y, norm_z
  output logic        out_tlast,  // run_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  fng_cmd_t cmd;
  fng_sts_t sts;
  logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;

  // Sequencer and configuration.
  fng_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_last  (out_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Arithmetic.
  fng_dp #(
    .NORM_FRAC_BITS (NORM_FRAC_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .pos_x  ($signed(in_tdata[31:0])),
    .pos_y  ($signed(in_tdata[63:32])),
    .pos_z  ($signed(in_tdata[95:64])),
    .cmd    (cmd),
    .sts    (sts),
    .norm_x (norm_x),
    .norm_y (norm_y),
    .norm_z (norm_z)
  );

  assign out_tdata = {norm_z, norm_y, norm_x};

endmodule

// ===== src/fng_checker.sv =====
// Port-level checks for the face normal generator, bound to the top level.
// Depends on face_normal_generator_top.
`timescale 1ns / 1ps
module fng_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast
);

  // Inputs are not taken while normals are being shown.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while output valid");

  // The last normal of a vertex frees the input side.
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("input not ready after last normal");

  // A stalled normal stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled normal changed");

endmodule

bind face_normal_generator_top fng_checker u_chk (.*);

// ===== test/tb_top.sv =====
// Testbench for face_normal_generator_top: drives vertex streams in all four
// primitive modes and checks every normal against a predictor of the block.
// Depends on fng_pkg and the face normal generator RTL.
`timescale 1ns / 1ps
module tb_top import fng_pkg::*; ();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        last;
  } normal_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               pend;
    bit                 has_exp;
    logic [15:0]        ex;
    logic [15:0]        ey;
    logic [15:0]        ez;
  } vrow_t;

  normal_t pending_normals[$];
  int      errors = 0;
  bit      quiet_phase = 1'b0;
  int      rx_hold = 0;
  bit      long_hold_req = 1'b0;
  bit      long_hold_done = 1'b0;

  // Predictor state.
  logic [1:0]         mode_q = PRIM_LIST;
  logic signed [63:0] va[3];
  logic signed [63:0] vb[3];
  int unsigned        phase_q = 0;
  logic [15:0]        poly_n[3];

  face_normal_generator_top dut (.*);

  always #2 clk = ~clk;

  function automatic logic [63:0] absv(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Signed division by 2^k rounding toward zero.
  function automatic logic signed [63:0] div_pow2(input logic signed [63:0] v, input int k);
    logic [63:0] m;
    m = absv(v) >> k;
    return v < 0 ? -$signed(m) : $signed(m);
  endfunction

  // Append one expected normal to the scoreboard queue.
  task automatic queue_normal(input logic [15:0] a, input logic [15:0] b,
                              input logic [15:0] c, input logic last);
    normal_t w;
    w = '{a, b, c, last};
    pending_normals = {pending_normals, w};
  endtask

  task automatic flat_normal(input logic signed [63:0] p0[3], input logic signed [63:0] p1[3],
                             input logic signed [63:0] p2[3], output logic [15:0] n[3]);
    logic signed [63:0] d[3];
    logic signed [63:0] e[3];
    logic signed [63:0] c[3];
    logic [63:0] m, s, len, q;
    int k, top;
    m = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = p0[i] - p1[i];
      e[i] = p1[i] - p2[i];
      if (absv(d[i]) > m) m = absv(d[i]);
      if (absv(e[i]) > m) m = absv(e[i]);
    end
    k = 0;
    while (k < 2 && (m >> k) > (64'd1 << 30)) k++;
    for (int i = 0; i < 3; i++) begin
      d[i] = div_pow2(d[i], k);
      e[i] = div_pow2(e[i], k);
    end
    c[0] = d[1] * e[2] - d[2] * e[1];
    c[1] = d[2] * e[0] - d[0] * e[2];
    c[2] = d[0] * e[1] - d[1] * e[0];
    m = 0;
    for (int i = 0; i < 3; i++) if (absv(c[i]) > m) m = absv(c[i]);
    for (int i = 0; i < 3; i++) n[i] = '0;
    if (m != 0) begin
      top = 0;
      while (top < 63 && (m >> (top + 1)) != 0) top++;
      for (int i = 0; i < 3; i++) begin
        if (top > 29) c[i] = div_pow2(c[i], top - 29);
        else c[i] = c[i] <<< (29 - top);
        s = s + absv(c[i]) * absv(c[i]);
      end
      len = int_sqrt(s);
      if (len != 0) begin
        for (int i = 0; i < 3; i++) begin
          q = ((absv(c[i]) << 14) + (len >> 1)) / len;
          if (q > 32767) q = 32767;
          n[i] = c[i] < 0 ? -q[15:0] : q[15:0];
        end
      end
    end
  endtask

  // Advance the predictor by one accepted vertex and queue its normals.
  task automatic predict_vertex(input vrow_t r);
    logic signed [63:0] v[3];
    logic [15:0] n[3];
    int unsigned stride, nxt;
    v[0] = r.x;
    v[1] = r.y;
    v[2] = r.z;
    if (mode_q == PRIM_POLY) begin
      if (phase_q == 2) begin
        flat_normal(va, vb, v, poly_n);
        for (int i = 0; i < 3; i++)
          queue_normal(poly_n[0], poly_n[1], poly_n[2], i == 2);
      end else if (phase_q >= 3) begin
        queue_normal(poly_n[0], poly_n[1], poly_n[2], 1'b1);
      end
      nxt = phase_q >= 3 ? 3 : phase_q + 1;
    end else begin
      stride = mode_q == PRIM_LIST ? 3 : (mode_q == PRIM_STRIP ? 2 : 4);
      if (phase_q >= 2 && (phase_q - 2) % stride == 0) begin
        flat_normal(va, vb, v, n);
        if (r.has_exp && (n[0] != r.ex || n[1] != r.ey || n[2] != r.ez)) begin
          $display("%0t predictor table row: expected %h %h %h, actual %h %h %h",
                   $time, r.ex, r.ey, r.ez, n[0], n[1], n[2]);
          errors++;
        end
        for (int i = 0; i < stride; i++)
          queue_normal(n[0], n[1], n[2], i == stride - 1);
      end
      nxt = phase_q + 1;
      if (nxt >= 2) nxt = 2 + (nxt - 2) % stride;
    end
    for (int i = 0; i < 3; i++) begin
      va[i] = vb[i];
      vb[i] = v[i];
    end
    phase_q = r.pend ? 0 : nxt;
  endtask

  // Offer one vertex; valid stays up after the transfer until the next idle or drain.
  task automatic send_vertex(input vrow_t r);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.z, r.y, r.x};
    in_tlast  <= r.pend;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_vertex(r);
  endtask

  task automatic drain_all();
    in_tvalid <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_q = m;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return $signed($urandom_range(0, 255)) - 128;
      default: return $signed($urandom());
    endcase
  endfunction

  // Result receiver with random back-pressure and a requested long hold.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_normals.size() == 0) begin
          $display("%0t unexpected normal: expected none, actual %h last %b",
                   $time, out_tdata, out_tlast);
          errors++;
        end else begin
          normal_t w;
          w = pending_normals.pop_front();
          if (out_tdata != {w.nz, w.ny, w.nx} || out_tlast != w.last) begin
            $display("%0t normal mismatch: expected %h last %b, actual %h last %b",
                     $time, {w.nz, w.ny, w.nx}, w.last, out_tdata, out_tlast);
            errors++;
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        rx_hold <= 400;
        out_tready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        rx_hold <= $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    vrow_t tbl[11];
    vrow_t r;
    int len;
    for (int i = 0; i < 3; i++) begin
      va[i] = 0;
      vb[i] = 0;
      poly_n[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: unit triangle, degenerate triangle, extreme coordinates,
    // and a short primitive.
    tbl[0]  = '{0, 0, 0, 0, 0, 0, 0, 0};
    tbl[1]  = '{32'sh10000, 0, 0, 0, 0, 0, 0, 0};
    tbl[2]  = '{32'sh10000, 32'sh10000, 0, 1, 1, 16'h0, 16'h0, 16'h4000};
    tbl[3]  = '{5, 5, 5, 0, 0, 0, 0, 0};
    tbl[4]  = '{5, 5, 5, 0, 0, 0, 0, 0};
    tbl[5]  = '{5, 5, 5, 1, 1, 16'h0, 16'h0, 16'h0};
    tbl[6]  = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0, 0};
    tbl[7]  = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0};
    tbl[8]  = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 0, 0, 0, 0};
    tbl[9]  = '{1, 2, 3, 0, 0, 0, 0, 0};
    tbl[10] = '{4, 5, 6, 1, 0, 0, 0, 0};
    foreach (tbl[i]) send_vertex(tbl[i]);
    drain_all();

    // Each mode once with extremes, switching mode mid-primitive.
    for (int m = 0; m < 4; m++) begin
      write_mode(m[1:0]);
      for (int i = 0; i < 3; i++) begin
        r = '{rand_coord(), rand_coord(), rand_coord(), 0, 0, 0, 0, 0};
        send_vertex(r);
      end
      drain_all();
    end
    write_mode(PRIM_LIST);
    r = '{7, -3, 11, 1, 0, 0, 0, 0};
    send_vertex(r);
    drain_all();

    // Long receiver hold while vertices keep coming.
    write_mode(PRIM_QUAD);
    @(posedge clk);
    long_hold_req <= 1'b1;
    for (int i = 0; i < 12; i++) begin
      r = '{rand_coord(), rand_coord(), rand_coord(), i == 11, 0, 0, 0, 0};
      send_vertex(r);
    end
    drain_all();

    // Random primitives across all modes.
    for (int p = 0; p < 40; p++) begin
      write_mode(2'($urandom_range(0, 3)));
      len = $urandom_range(1, 8);
      if (p == 39) quiet_phase = 1'b1;
      for (int i = 0; i < len; i++) begin
        r = '{rand_coord(), rand_coord(), rand_coord(),
              (i == len - 1) || ($urandom_range(0, 15) == 0), 0, 0, 0, 0};
        send_vertex(r);
      end
      if ($urandom_range(0, 1) == 0) begin
        r = '{rand_coord(), rand_coord(), rand_coord(), 1, 0, 0, 0, 0};
        send_vertex(r);
      end
      drain_all();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
